// ===== src/pulse_distance_key_transmitter_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pulse-distance key transmitter
// Clocked property checks that report through $error; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef PULSE_DISTANCE_KEY_TRANSMITTER_UNIT_ASSERT_SVH
`define PULSE_DISTANCE_KEY_TRANSMITTER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// check a property on clk, off while rst_n is low
`define PDKT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// check a property on clk, also during reset
`define PDKT_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PDKT_ASSERT(label, prop, msg)
`define PDKT_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// ===== src/pdkt_pkg.sv =====
// ----------------------------------------------------------------------------
// pdkt_pkg
// Types and constants shared by the key transmitter modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pdkt_pkg;

    localparam int SYMBOL_W = 9;
    localparam int ENTRY_W  = 16;
    localparam int GAP_W    = 16;
    localparam int CODE_W   = 8;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_PRESS   = 2'd1;
    localparam logic [1:0] OP_RELEASE = 2'd2;
    localparam logic [1:0] OP_WRITE   = 2'd3;

    localparam logic [1:0] MOD_NORMAL  = 2'd0;
    localparam logic [1:0] MOD_SHIFT   = 2'd1;
    localparam logic [1:0] MOD_CONTROL = 2'd2;
    localparam logic [1:0] MOD_ALTGR   = 2'd3;

    localparam logic [1:0] CFG_GAP_BIT_ONE  = 2'd0;
    localparam logic [1:0] CFG_GAP_BIT_ZERO = 2'd1;
    localparam logic [1:0] CFG_GAP_WORD     = 2'd2;
    localparam logic [1:0] CFG_GAP_END      = 2'd3;

    localparam logic [GAP_W-1:0] GAP_BIT_ONE_RST  = 16'd6144;
    localparam logic [GAP_W-1:0] GAP_BIT_ZERO_RST = 16'd4096;
    localparam logic [GAP_W-1:0] GAP_WORD_RST     = 16'd12288;
    localparam logic [GAP_W-1:0] GAP_END_RST      = 16'd24576;

    localparam logic [SYMBOL_W-1:0] CTRL_FIRST  = 9'h061;
    localparam logic [SYMBOL_W-1:0] CTRL_LAST   = 9'h07a;
    localparam logic [SYMBOL_W-1:0] CTRL_OFFSET = 9'h060;

    localparam logic [ENTRY_W-1:0] ENTRY_EMPTY = 16'hffff;
    localparam int FORCE_SHIFT_BIT   = 8;
    localparam int FORCE_UNSHIFT_BIT = 12;

    typedef struct packed {
        logic [1:0]          opcode;
        logic [1:0]          modifier;
        logic [SYMBOL_W-1:0] symbol;
        logic                release_any;
        logic [ENTRY_W-1:0]  entry_word;
    } pdkt_in_t;

    typedef struct packed {
        logic strobe_res;
        logic busy_res;
    } pdkt_out_t;

    typedef struct packed {
        logic                valid;
        logic [1:0]          opcode;
        logic [1:0]          modifier;
        logic [SYMBOL_W-1:0] symbol;
        logic                release_any;
        logic                in_range;
    } pdkt_stage_t;

endpackage

`default_nettype wire

// ===== src/pdkt_ram.sv =====
// ----------------------------------------------------------------------------
// pdkt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdkt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== src/pdkt_front.sv =====
// ----------------------------------------------------------------------------
// pdkt_front
// Input acceptance, table clearing sweep, table write and lookup issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pdkt_front
    import pdkt_pkg::*;
#(
    parameter int TABLE_DEPTH = 512,
    localparam int AW = $clog2(TABLE_DEPTH)
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire pdkt_in_t           in_item,
    input  wire logic               advance,
    input  wire logic               control_held,
    output logic                    ram_we,
    output logic [AW-1:0]           ram_waddr,
    output logic [ENTRY_W-1:0]      ram_wdata,
    output logic                    ram_re,
    output logic [AW-1:0]           ram_raddr,
    output pdkt_stage_t             stage
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

    logic                clearing_reg;
    logic                clearing_next;
    logic [AW-1:0]       clr_addr_reg;
    logic [AW-1:0]       clr_addr_next;
    pdkt_stage_t         stage_reg;
    pdkt_stage_t         stage_next;
    logic                accept;
    logic                is_press;
    logic                ctrl_eff;
    logic [SYMBOL_W-1:0] sym_sel;
    logic                in_range;

    assign in_stall = clearing_reg || (stage_reg.valid && !advance);
    assign accept   = in_valid && !in_stall;
    assign is_press = in_item.opcode == OP_PRESS;

    // forward the control flag of the item still waiting in the execute stage
    always_comb
    begin
        ctrl_eff = control_held;
        if (stage_reg.valid && stage_reg.modifier == MOD_CONTROL)
        begin
            if (stage_reg.opcode == OP_PRESS)
            begin
                ctrl_eff = 1'b1;
            end
            else if (stage_reg.opcode == OP_RELEASE)
            begin
                ctrl_eff = 1'b0;
            end
        end
    end

    always_comb
    begin
        sym_sel = in_item.symbol;
        if (is_press && ctrl_eff && in_item.symbol >= CTRL_FIRST
            && in_item.symbol <= CTRL_LAST)
        begin
            sym_sel = in_item.symbol - CTRL_OFFSET;
        end
    end

    assign in_range = 32'(sym_sel) < TABLE_DEPTH;

    always_comb
    begin
        if (clearing_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = ENTRY_EMPTY;
        end
        else
        begin
            ram_we    = accept && in_item.opcode == OP_WRITE && in_range;
            ram_waddr = AW'(sym_sel);
            ram_wdata = in_item.entry_word;
        end
    end

    assign ram_re    = accept && is_press && in_item.modifier == MOD_NORMAL && in_range;
    assign ram_raddr = AW'(sym_sel);

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_addr_next = clr_addr_reg;
        if (clearing_reg)
        begin
            if (clr_addr_reg == LAST_ADDR)
            begin
                clearing_next = 1'b0;
            end
            else
            begin
                clr_addr_next = clr_addr_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        stage_next = stage_reg;
        if (accept)
        begin
            stage_next.valid       = 1'b1;
            stage_next.opcode      = in_item.opcode;
            stage_next.modifier    = in_item.modifier;
            stage_next.symbol      = sym_sel;
            stage_next.release_any = in_item.release_any;
            stage_next.in_range    = in_range;
        end
        else if (advance)
        begin
            stage_next.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
            stage_reg    <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_addr_reg <= clr_addr_next;
            stage_reg    <= stage_next;
        end
    end

    assign stage = stage_reg;

endmodule

`default_nettype wire

// ===== src/pdkt_exec.sv =====
// ----------------------------------------------------------------------------
// pdkt_exec
// Key state, frame sequencer, gap timer and result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "pulse_distance_key_transmitter_unit_assert.svh"

module pdkt_exec
    import pdkt_pkg::*;
#(
    parameter int BITS_PER_COPY = 7
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_write_en,
    input  wire logic [1:0]         cfg_index,
    input  wire logic [GAP_W-1:0]   cfg_data,
    input  wire pdkt_stage_t        stage,
    input  wire logic [ENTRY_W-1:0] rd_data,
    output logic                    advance,
    output logic                    control_held,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output pdkt_out_t               out_item
);

    localparam int PW = $clog2(2 * BITS_PER_COPY + 3);
    localparam logic [PW-1:0] POS_IDLE   = '0;
    localparam logic [PW-1:0] POS_FIRST  = PW'(1);
    localparam logic [PW-1:0] POS_LAST1  = PW'(BITS_PER_COPY);
    localparam logic [PW-1:0] POS_SECOND = PW'(BITS_PER_COPY + 1);
    localparam logic [PW-1:0] POS_LAST2  = PW'(2 * BITS_PER_COPY + 1);

    logic [GAP_W-1:0]    gap_one_reg, gap_zero_reg, gap_word_reg, gap_end_reg;
    logic [CODE_W-1:0]   current_code_reg, current_code_next;
    logic                current_valid_reg, current_valid_next;
    logic [CODE_W-1:0]   next_code_reg, next_code_next;
    logic                next_valid_reg, next_valid_next;
    logic [SYMBOL_W-1:0] held_symbol_reg, held_symbol_next;
    logic                release_pending_reg, release_pending_next;
    logic                shift_held_reg, shift_held_next;
    logic                control_held_reg, control_held_next;
    logic [PW-1:0]       position_reg, position_next;
    logic [GAP_W-1:0]    gap_reg, gap_next;
    logic [CODE_W-1:0]   shifter_reg, shifter_next;
    logic                out_valid_reg;
    pdkt_out_t           out_item_reg;
    logic                execute;
    logic                strobe;
    logic                bit0;
    logic [CODE_W-1:0]   press_code;
    logic [CODE_W-1:0]   frame_code;
    logic                frame_valid;

    assign advance      = !out_valid_reg || !out_stall;
    assign execute      = stage.valid && advance;
    assign control_held = control_held_reg;

    always_comb
    begin
        bit0 = rd_data[0] || rd_data[FORCE_SHIFT_BIT] || shift_held_reg;
        if (rd_data[FORCE_UNSHIFT_BIT])
        begin
            bit0 = 1'b0;
        end
        press_code = {rd_data[CODE_W-1:1], !bit0};
    end

    always_comb
    begin
        current_code_next    = current_code_reg;
        current_valid_next   = current_valid_reg;
        next_code_next       = next_code_reg;
        next_valid_next      = next_valid_reg;
        held_symbol_next     = held_symbol_reg;
        release_pending_next = release_pending_reg;
        shift_held_next      = shift_held_reg;
        control_held_next    = control_held_reg;
        position_next        = position_reg;
        gap_next             = gap_reg;
        shifter_next         = shifter_reg;
        strobe               = 1'b0;
        frame_code           = current_code_reg;
        frame_valid          = current_valid_reg;
        if (execute)
        begin
            case (stage.opcode)
                OP_TICK:
                begin
                    if (position_reg != POS_IDLE)
                    begin
                        if (gap_reg > GAP_W'(1))
                        begin
                            gap_next = gap_reg - 1'b1;
                        end
                        else if (position_reg <= POS_LAST1)
                        begin
                            strobe        = 1'b1;
                            position_next = position_reg + 1'b1;
                            if (position_reg < POS_LAST1)
                            begin
                                gap_next     = shifter_reg[0] ? gap_one_reg : gap_zero_reg;
                                shifter_next = shifter_reg >> 1;
                            end
                            else
                            begin
                                gap_next = gap_word_reg;
                            end
                        end
                        else if (position_reg == POS_SECOND)
                        begin
                            strobe        = 1'b1;
                            position_next = position_reg + 1'b1;
                            gap_next      = current_code_reg[0] ? gap_one_reg : gap_zero_reg;
                            shifter_next  = current_code_reg >> 1;
                        end
                        else if (position_reg <= POS_LAST2)
                        begin
                            strobe        = 1'b1;
                            position_next = position_reg + 1'b1;
                            if (position_reg < POS_LAST2)
                            begin
                                gap_next     = shifter_reg[0] ? gap_one_reg : gap_zero_reg;
                                shifter_next = shifter_reg >> 1;
                            end
                            else
                            begin
                                gap_next = gap_end_reg;
                            end
                        end
                        else
                        begin
                            // frame end: the locked key replaces the current one, but a pending release wins
                            if (next_valid_reg)
                            begin
                                frame_code  = next_code_reg;
                                frame_valid = 1'b1;
                            end
                            if (release_pending_reg)
                            begin
                                frame_valid = 1'b0;
                            end
                            current_code_next    = frame_code;
                            current_valid_next   = frame_valid;
                            next_valid_next      = 1'b0;
                            release_pending_next = 1'b0;
                            if (frame_valid)
                            begin
                                strobe        = 1'b1;
                                position_next = POS_FIRST;
                                gap_next      = frame_code[0] ? gap_one_reg : gap_zero_reg;
                                shifter_next  = frame_code >> 1;
                            end
                            else
                            begin
                                position_next = POS_IDLE;
                                gap_next      = '0;
                            end
                        end
                    end
                end
                OP_PRESS:
                begin
                    case (stage.modifier)
                        MOD_SHIFT:   shift_held_next = 1'b1;
                        MOD_CONTROL: control_held_next = 1'b1;
                        MOD_NORMAL:
                        begin
                            if (stage.in_range && rd_data != ENTRY_EMPTY)
                            begin
                                release_pending_next = 1'b0;
                                held_symbol_next     = stage.symbol;
                                if (!current_valid_reg)
                                begin
                                    current_code_next  = press_code;
                                    current_valid_next = 1'b1;
                                    strobe             = 1'b1;
                                    position_next      = POS_FIRST;
                                    gap_next     = press_code[0] ? gap_one_reg : gap_zero_reg;
                                    shifter_next = press_code >> 1;
                                end
                                else
                                begin
                                    next_code_next  = press_code;
                                    next_valid_next = 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                OP_RELEASE:
                begin
                    case (stage.modifier)
                        MOD_SHIFT:   shift_held_next = 1'b0;
                        MOD_CONTROL: control_held_next = 1'b0;
                        MOD_NORMAL:
                        begin
                            if (stage.release_any || stage.symbol == held_symbol_reg)
                            begin
                                release_pending_next = 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_one_reg         <= GAP_BIT_ONE_RST;
            gap_zero_reg        <= GAP_BIT_ZERO_RST;
            gap_word_reg        <= GAP_WORD_RST;
            gap_end_reg         <= GAP_END_RST;
            current_code_reg    <= '0;
            current_valid_reg   <= 1'b0;
            next_code_reg       <= '0;
            next_valid_reg      <= 1'b0;
            held_symbol_reg     <= '0;
            release_pending_reg <= 1'b0;
            shift_held_reg      <= 1'b0;
            control_held_reg    <= 1'b0;
            position_reg        <= POS_IDLE;
            gap_reg             <= '0;
            shifter_reg         <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_GAP_BIT_ONE:  gap_one_reg  <= cfg_data;
                    CFG_GAP_BIT_ZERO: gap_zero_reg <= cfg_data;
                    CFG_GAP_WORD:     gap_word_reg <= cfg_data;
                    CFG_GAP_END:      gap_end_reg  <= cfg_data;
                    default: ;
                endcase
            end
            current_code_reg    <= current_code_next;
            current_valid_reg   <= current_valid_next;
            next_code_reg       <= next_code_next;
            next_valid_reg      <= next_valid_next;
            held_symbol_reg     <= held_symbol_next;
            release_pending_reg <= release_pending_next;
            shift_held_reg      <= shift_held_next;
            control_held_reg    <= control_held_next;
            position_reg        <= position_next;
            gap_reg             <= gap_next;
            shifter_reg         <= shifter_next;
            if (execute)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (execute)
        begin
            out_item_reg.strobe_res <= strobe;
            out_item_reg.busy_res   <= position_next != POS_IDLE;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    `PDKT_ASSERT(a_strobe_busy, out_valid_reg && out_item_reg.strobe_res |-> out_item_reg.busy_res, "strobe without busy")
    `PDKT_ASSERT(a_busy_has_key, position_reg != POS_IDLE |-> current_valid_reg, "frame running without a current key")
    `PDKT_ASSERT(a_idle_gap_zero, position_reg == POS_IDLE |-> gap_reg == '0, "gap timer running while idle")
    `PDKT_ASSERT(a_locked_needs_current, next_valid_reg |-> current_valid_reg, "locked key without a current key")

endmodule

`default_nettype wire

// ===== src/pulse_distance_key_transmitter_unit.sv =====
// ----------------------------------------------------------------------------
// pulse_distance_key_transmitter_unit
// Turns key events into repeated pulse-distance strobe frames.
// ----------------------------------------------------------------------------
// Input channel in_valid / in_stall / in_item carries ticks, key presses,
// key releases and translation table writes. Every accepted item gives
// exactly one result on out_valid / out_stall / out_item: the strobe pulse
// of that step and whether a frame is running after it.
// The accepting edge registers the table lookup in the RAM together with the
// item in the execute stage; once that stage advances, the key and frame
// update is written into the output register.
// One item is accepted per cycle while results drain.
// When the receiver stalls, one item waits in the execute stage and the
// input stalls behind it; nothing is dropped.
// After reset the table RAM is swept to empty entries, one entry per cycle,
// through all TABLE_DEPTH entries; in_stall stays high meanwhile. Gap registers are
// written through cfg_write_en / cfg_index / cfg_data at any time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pulse_distance_key_transmitter_unit
    import pdkt_pkg::*;
#(
    parameter int TABLE_DEPTH   = 512,
    parameter int BITS_PER_COPY = 7
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_write_en,
    input  wire logic [1:0]       cfg_index,
    input  wire logic [GAP_W-1:0] cfg_data,
    input  wire logic             in_valid,
    output logic                  in_stall,
    input  wire pdkt_in_t         in_item,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output pdkt_out_t             out_item
);

    localparam int AW = $clog2(TABLE_DEPTH);

    logic               advance;
    logic               control_held;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [ENTRY_W-1:0] ram_wdata;
    logic               ram_re;
    logic [AW-1:0]      ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    pdkt_stage_t        stage;

    pdkt_front #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_item      (in_item),
        .advance      (advance),
        .control_held (control_held),
        .ram_we       (ram_we),
        .ram_waddr    (ram_waddr),
        .ram_wdata    (ram_wdata),
        .ram_re       (ram_re),
        .ram_raddr    (ram_raddr),
        .stage        (stage)
    );

    pdkt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_key_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    pdkt_exec #(
        .BITS_PER_COPY (BITS_PER_COPY)
    ) u_exec (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .stage        (stage),
        .rd_data      (ram_rdata),
        .advance      (advance),
        .control_held (control_held),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_item     (out_item)
    );

endmodule

`default_nettype wire
